// File: rtl/line_follower_steering_mixer_defines.svh
// assertion macros for the line follower steering mixer
// included by the rtl files that carry assertions, no other dependencies
`ifndef LINE_FOLLOWER_STEERING_MIXER_DEFINES_SVH
`define LINE_FOLLOWER_STEERING_MIXER_DEFINES_SVH
`ifndef SYNTHESIS
`define LFSM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LFSM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LFSM_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define LFSM_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/lfsm_pkg.sv
// shared widths, request codes, constants and divider interface types
// no dependencies
package lfsm_pkg;

  localparam int SAMPLE_W = 12;
  localparam int DUTY_W   = 8;
  localparam int QUO_W    = 8;
  localparam int NUM_W    = SAMPLE_W + QUO_W;
  localparam int CNT_W    = $clog2(QUO_W);
  localparam int REQ_W    = 2;

  localparam logic [REQ_W-1:0] REQ_CAL_START  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CAL_SAMPLE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DRIVE      = 2'd2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX      = 12'd4095;
  localparam logic [DUTY_W-1:0]   DUTY_MAX        = 8'd255;
  localparam logic [DUTY_W:0]     SPEED_MID       = 9'd128;
  localparam logic [DUTY_W-1:0]   INNER_SCALE_NUM = 8'd180;
  localparam logic [SAMPLE_W-1:0] INNER_SCALE_DEN = 12'd255;

  typedef struct packed {
    logic                start;
    logic [NUM_W-1:0]    num;
    logic [SAMPLE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: rtl/lfsm_div.sv
// shared restoring divider, one quotient bit per cycle
// needs lfsm_pkg; quotient must fit QUO_W bits (num < den << QUO_W)
module lfsm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  lfsm_pkg::div_req_t req,
  output lfsm_pkg::div_rsp_t rsp
);

  logic [lfsm_pkg::NUM_W-1:0]    rem_r;
  logic [lfsm_pkg::SAMPLE_W-1:0] den_r;
  logic [lfsm_pkg::CNT_W-1:0]    cnt_r;
  logic [lfsm_pkg::QUO_W-1:0]    quo_r;
  logic                          busy_r;
  logic                          done_r;

  logic [lfsm_pkg::NUM_W-1:0] shifted;
  logic                       ge;

  assign shifted = {{(lfsm_pkg::NUM_W-lfsm_pkg::SAMPLE_W){1'b0}}, den_r} << cnt_r;
  assign ge      = (rem_r >= shifted);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      den_r <= req.den;
      cnt_r <= lfsm_pkg::CNT_W'(lfsm_pkg::QUO_W - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_r - shifted) : rem_r;
      quo_r <= {quo_r[lfsm_pkg::QUO_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// File: rtl/line_follower_steering_mixer.sv
// top level: calibration store, sequencer and output register of the steering mixer
// needs lfsm_pkg, lfsm_div and line_follower_steering_mixer_defines.svh
//
//   channel | ports                                              | direction
//   in      | in_valid, in_stall, in_req_type, in_*_sample       | item in
//   out     | out_valid, out_stall, out_*_duty, out_range_fault  | item out
//
// a calibration or unused-code item goes from idle straight to the done state; a drive item also
// normalises both samples, then mixes; its time is set by the shared divider, up to three divisions
// in_stall is high while an item is in work; a stalled result holds the next item at its last step
// rst_n is synchronous; stored extremes reset to min 0 and max 4095
`include "line_follower_steering_mixer_defines.svh"

module line_follower_steering_mixer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lfsm_pkg::REQ_W-1:0]    in_req_type,
  input  logic [lfsm_pkg::SAMPLE_W-1:0] in_left_sample,
  input  logic [lfsm_pkg::SAMPLE_W-1:0] in_right_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lfsm_pkg::DUTY_W-1:0]   out_left_fwd_duty,
  output logic [lfsm_pkg::DUTY_W-1:0]   out_left_rev_duty,
  output logic [lfsm_pkg::DUTY_W-1:0]   out_right_fwd_duty,
  output logic [lfsm_pkg::DUTY_W-1:0]   out_right_rev_duty,
  output logic                          out_range_fault
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_NORM_R = 9'b000000010,
    S_WAIT_R = 9'b000000100,
    S_NORM_L = 9'b000001000,
    S_WAIT_L = 9'b000010000,
    S_MIX    = 9'b000100000,
    S_INNER  = 9'b001000000,
    S_WAIT_S = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  localparam int SW = lfsm_pkg::SAMPLE_W;
  localparam int DW = lfsm_pkg::DUTY_W;

  state_t state_r, state_nxt;

  logic [SW-1:0] left_min_r, left_max_r, right_min_r, right_max_r;
  logic [SW-1:0] left_min_nxt, left_max_nxt, right_min_nxt, right_max_nxt;
  logic [SW-1:0] ls_r, rs_r, ls_nxt, rs_nxt;
  logic [DW-1:0] nr_r, nl_r, nr_nxt, nl_nxt;
  logic          fault_r, fault_nxt;
  logic          drive_r, drive_nxt;
  logic          r_outer_r, r_outer_nxt;
  logic [DW-1:0] mag_r, mag_nxt;
  logic [DW-1:0] outer_r, outer_nxt;
  logic [DW-1:0] inner_fwd_r, inner_fwd_nxt;
  logic [DW-1:0] inner_rev_r, inner_rev_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_lf_r, out_lr_r, out_rf_r, out_rr_r;
  logic [DW-1:0] out_lf_nxt, out_lr_nxt, out_rf_nxt, out_rr_nxt;
  logic          out_fault_r, out_fault_nxt;

  lfsm_pkg::div_req_t div_req;
  lfsm_pkg::div_rsp_t div_rsp;

  logic [SW-1:0]               sel_s, sel_lo, sel_hi, diff, span;
  logic [DW+1:0]               three_mag;
  logic [DW:0]                 half;
  logic [DW-1:0]               neg_t;
  logic                        out_free;
  logic                        accept;

  lfsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign sel_s  = (state_r == S_NORM_R) ? rs_r : ls_r;
  assign sel_lo = (state_r == S_NORM_R) ? right_min_r : left_min_r;
  assign sel_hi = (state_r == S_NORM_R) ? right_max_r : left_max_r;
  assign diff   = sel_s - sel_lo;
  assign span   = sel_hi - sel_lo;

  assign three_mag = {2'b00, mag_r} + {1'b0, mag_r, 1'b0};
  assign half      = three_mag[DW+1:1];
  assign neg_t     = DW'(half - lfsm_pkg::SPEED_MID);

  always_comb begin
    state_nxt     = state_r;
    left_min_nxt  = left_min_r;
    left_max_nxt  = left_max_r;
    right_min_nxt = right_min_r;
    right_max_nxt = right_max_r;
    ls_nxt        = ls_r;
    rs_nxt        = rs_r;
    nr_nxt        = nr_r;
    nl_nxt        = nl_r;
    fault_nxt     = fault_r;
    drive_nxt     = drive_r;
    r_outer_nxt   = r_outer_r;
    mag_nxt       = mag_r;
    outer_nxt     = outer_r;
    inner_fwd_nxt = inner_fwd_r;
    inner_rev_nxt = inner_rev_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_lf_nxt    = out_lf_r;
    out_lr_nxt    = out_lr_r;
    out_rf_nxt    = out_rf_r;
    out_rr_nxt    = out_rr_r;
    out_fault_nxt = out_fault_r;
    div_req.start = 1'b0;
    div_req.num   = {diff, {DW{1'b0}}} - {{DW{1'b0}}, diff};
    div_req.den   = span;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ls_nxt    = in_left_sample;
          rs_nxt    = in_right_sample;
          fault_nxt = 1'b0;
          drive_nxt = 1'b0;
          state_nxt = S_DONE;
          case (in_req_type)
            lfsm_pkg::REQ_CAL_START: begin
              left_max_nxt  = '0;
              left_min_nxt  = lfsm_pkg::SAMPLE_MAX;
              right_max_nxt = '0;
              right_min_nxt = lfsm_pkg::SAMPLE_MAX;
            end
            lfsm_pkg::REQ_CAL_SAMPLE: begin
              if (in_left_sample < left_min_r) left_min_nxt = in_left_sample;
              if (in_left_sample > left_max_r) left_max_nxt = in_left_sample;
              if (in_right_sample < right_min_r) right_min_nxt = in_right_sample;
              if (in_right_sample > right_max_r) right_max_nxt = in_right_sample;
            end
            lfsm_pkg::REQ_DRIVE: begin
              drive_nxt = 1'b1;
              state_nxt = S_NORM_R;
            end
            default: begin
            end
          endcase
        end
      end
      S_NORM_R, S_NORM_L: begin
        if (sel_hi <= sel_lo) begin
          fault_nxt = 1'b1;
          if (state_r == S_NORM_R) nr_nxt = '0;
          else nl_nxt = '0;
          state_nxt = (state_r == S_NORM_R) ? S_NORM_L : S_MIX;
        end else if (sel_s <= sel_lo) begin
          if (state_r == S_NORM_R) nr_nxt = '0;
          else nl_nxt = '0;
          state_nxt = (state_r == S_NORM_R) ? S_NORM_L : S_MIX;
        end else if (sel_s >= sel_hi) begin
          if (state_r == S_NORM_R) nr_nxt = lfsm_pkg::DUTY_MAX;
          else nl_nxt = lfsm_pkg::DUTY_MAX;
          state_nxt = (state_r == S_NORM_R) ? S_NORM_L : S_MIX;
        end else begin
          div_req.start = 1'b1;
          state_nxt = (state_r == S_NORM_R) ? S_WAIT_R : S_WAIT_L;
        end
      end
      S_WAIT_R: begin
        if (div_rsp.done) begin
          nr_nxt    = div_rsp.quo;
          state_nxt = S_NORM_L;
        end
      end
      S_WAIT_L: begin
        if (div_rsp.done) begin
          nl_nxt    = div_rsp.quo;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        r_outer_nxt = (nr_r > nl_r);
        mag_nxt     = (nr_r > nl_r) ? (nr_r - nl_r) : (nl_r - nr_r);
        outer_nxt   = DW'(lfsm_pkg::SPEED_MID + {2'b00, mag_nxt[DW-1:1]});
        state_nxt   = S_INNER;
      end
      S_INNER: begin
        if (half <= lfsm_pkg::SPEED_MID) begin
          inner_fwd_nxt = DW'(lfsm_pkg::SPEED_MID - half);
          inner_rev_nxt = '0;
          state_nxt     = S_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = lfsm_pkg::NUM_W'({{DW{1'b0}}, neg_t} *
                                           {{DW{1'b0}}, lfsm_pkg::INNER_SCALE_NUM});
          div_req.den   = lfsm_pkg::INNER_SCALE_DEN;
          state_nxt     = S_WAIT_S;
        end
      end
      S_WAIT_S: begin
        if (div_rsp.done) begin
          inner_fwd_nxt = '0;
          inner_rev_nxt = div_rsp.quo;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (drive_r) begin
            out_lf_nxt    = r_outer_r ? inner_fwd_r : outer_r;
            out_lr_nxt    = r_outer_r ? inner_rev_r : '0;
            out_rf_nxt    = r_outer_r ? outer_r : inner_fwd_r;
            out_rr_nxt    = r_outer_r ? '0 : inner_rev_r;
            out_fault_nxt = fault_r;
          end else begin
            out_lf_nxt    = '0;
            out_lr_nxt    = '0;
            out_rf_nxt    = '0;
            out_rr_nxt    = '0;
            out_fault_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      left_min_r  <= '0;
      left_max_r  <= lfsm_pkg::SAMPLE_MAX;
      right_min_r <= '0;
      right_max_r <= lfsm_pkg::SAMPLE_MAX;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      left_min_r  <= left_min_nxt;
      left_max_r  <= left_max_nxt;
      right_min_r <= right_min_nxt;
      right_max_r <= right_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ls_r        <= ls_nxt;
    rs_r        <= rs_nxt;
    nr_r        <= nr_nxt;
    nl_r        <= nl_nxt;
    fault_r     <= fault_nxt;
    drive_r     <= drive_nxt;
    r_outer_r   <= r_outer_nxt;
    mag_r       <= mag_nxt;
    outer_r     <= outer_nxt;
    inner_fwd_r <= inner_fwd_nxt;
    inner_rev_r <= inner_rev_nxt;
    out_lf_r    <= out_lf_nxt;
    out_lr_r    <= out_lr_nxt;
    out_rf_r    <= out_rf_nxt;
    out_rr_r    <= out_rr_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_left_fwd_duty  = out_lf_r;
  assign out_left_rev_duty  = out_lr_r;
  assign out_right_fwd_duty = out_rf_r;
  assign out_right_rev_duty = out_rr_r;
  assign out_range_fault    = out_fault_r;

  `LFSM_ASSERT_IMP(a_start_when_free, clk, rst_n, div_req.start, !div_rsp.busy)
  `LFSM_ASSERT_IMP(a_done_while_waiting, clk, rst_n, div_rsp.done,
    (state_r == S_WAIT_R) || (state_r == S_WAIT_L) || (state_r == S_WAIT_S))
  `LFSM_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, accept, state_r != S_IDLE)
  `LFSM_ASSERT_IMP(a_one_direction, clk, rst_n, out_valid_r,
    ((out_lf_r == '0) || (out_lr_r == '0)) && ((out_rf_r == '0) || (out_rr_r == '0)))

endmodule

// File: tb/sv/tb_line_follower_steering_mixer.sv
// self-checking testbench for line_follower_steering_mixer: drives calibration, drive and unused-code items
// through randomly idling valid/stall channels and checks each result against a built-in predictor
// depends on lfsm_pkg and the line_follower_steering_mixer rtl
module tb_line_follower_steering_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RW = lfsm_pkg::REQ_W;
  localparam int SW = lfsm_pkg::SAMPLE_W;
  localparam int DW = lfsm_pkg::DUTY_W;

  localparam logic [RW-1:0] REQ_UNUSED = 2'd3;
  localparam int MID       = lfsm_pkg::SPEED_MID;
  localparam int FULL      = lfsm_pkg::DUTY_MAX;
  localparam int SCALE_NUM = lfsm_pkg::INNER_SCALE_NUM;
  localparam int SCALE_DEN = lfsm_pkg::INNER_SCALE_DEN;
  localparam int TOP       = lfsm_pkg::SAMPLE_MAX;
  localparam int ITEM_GOAL = 1225;
  localparam int SQUEEZE   = 300;
  localparam int DRAIN     = 64;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [RW-1:0] req;
    logic [SW-1:0] left;
    logic [SW-1:0] right;
  } sensor_item_t;

  typedef struct packed {
    logic [DW-1:0] left_fwd;
    logic [DW-1:0] left_rev;
    logic [DW-1:0] right_fwd;
    logic [DW-1:0] right_rev;
    logic          fault;
  } duty_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [RW-1:0] in_req_type = '0;
  logic [SW-1:0] in_left_sample = '0;
  logic [SW-1:0] in_right_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DW-1:0] out_left_fwd_duty;
  logic [DW-1:0] out_left_rev_duty;
  logic [DW-1:0] out_right_fwd_duty;
  logic [DW-1:0] out_right_rev_duty;
  logic out_range_fault;

  sensor_item_t sensor_items[$];
  duty_set_t    duty_expect[$];

  logic [SW-1:0] cal_left_lo = '0;
  logic [SW-1:0] cal_left_hi = lfsm_pkg::SAMPLE_MAX;
  logic [SW-1:0] cal_right_lo = '0;
  logic [SW-1:0] cal_right_hi = lfsm_pkg::SAMPLE_MAX;

  int  errors = 0;
  int  items_counted = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  send_gap = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;
  bit  squeeze_done = 1'b0;

  line_follower_steering_mixer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_left_sample     (in_left_sample),
    .in_right_sample    (in_right_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_fwd_duty  (out_left_fwd_duty),
    .out_left_rev_duty  (out_left_rev_duty),
    .out_right_fwd_duty (out_right_fwd_duty),
    .out_right_rev_duty (out_right_rev_duty),
    .out_range_fault    (out_range_fault)
  );

  always #5 clk = ~clk;

  function automatic int scale_reading(input int s, input int lo, input int hi, inout bit fault);
    int v;
    if (hi <= lo) begin
      fault = 1'b1;
      return 0;
    end
    if (s <= lo) return 0;
    v = (FULL * (s - lo)) / (hi - lo);
    return (v > FULL) ? FULL : v;
  endfunction

  function automatic int inner_wheel(input int mag);
    int t;
    t = MID - (3 * mag) / 2;
    if (t < 0) t = -(((-t) * SCALE_NUM) / SCALE_DEN);
    return t;
  endfunction

  function automatic void set_motor(input int speed, output logic [DW-1:0] fwd,
                                    output logic [DW-1:0] rev);
    if (speed > 0) begin
      fwd = DW'(speed);
      rev = '0;
    end else begin
      fwd = '0;
      rev = DW'(-speed);
    end
  endfunction

  task automatic predict_duties(input logic [RW-1:0] req, input logic [SW-1:0] l,
                                input logic [SW-1:0] r);
    duty_set_t e;
    bit bad;
    int nl, nr, d, lsp, rsp;
    e = '0;
    bad = 1'b0;
    case (req)
      lfsm_pkg::REQ_CAL_START: begin
        cal_left_hi = '0;
        cal_left_lo = lfsm_pkg::SAMPLE_MAX;
        cal_right_hi = '0;
        cal_right_lo = lfsm_pkg::SAMPLE_MAX;
      end
      lfsm_pkg::REQ_CAL_SAMPLE: begin
        if (l < cal_left_lo) cal_left_lo = l;
        if (l > cal_left_hi) cal_left_hi = l;
        if (r < cal_right_lo) cal_right_lo = r;
        if (r > cal_right_hi) cal_right_hi = r;
      end
      lfsm_pkg::REQ_DRIVE: begin
        nr = scale_reading(r, cal_right_lo, cal_right_hi, bad);
        nl = scale_reading(l, cal_left_lo, cal_left_hi, bad);
        d = nr - nl;
        if (d > 0) begin
          rsp = MID + d / 2;
          lsp = inner_wheel(d);
        end else begin
          lsp = MID + (-d) / 2;
          rsp = inner_wheel(-d);
        end
        set_motor(lsp, e.left_fwd, e.left_rev);
        set_motor(rsp, e.right_fwd, e.right_rev);
        e.fault = bad;
      end
      default: begin
      end
    endcase
    duty_expect.push_back(e);
  endtask

  task automatic add_item(input logic [RW-1:0] req, input int l, input int r);
    sensor_items.push_back('{req, SW'(l), SW'(r)});
    if (req != REQ_UNUSED) items_counted++;
  endtask

  function automatic int near_reading(input int c, input int spread);
    int v;
    v = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > TOP) v = TOP;
    return v;
  endfunction

  task automatic drive_next();
    in_valid <= 1'b1;
    in_req_type <= sensor_items[0].req;
    in_left_sample <= sensor_items[0].left;
    in_right_sample <= sensor_items[0].right;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      predict_duties(in_req_type, in_left_sample, in_right_sample);
      void'(sensor_items.pop_front());
      items_taken++;
      if (items_taken % 90 == 0) send_calm = !send_calm;
      send_gap = send_calm ? 0 : $urandom_range(0, 8);
      if (send_gap == 0 && sensor_items.size() != 0) begin
        drive_next();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (sensor_items.size() != 0) begin
        drive_next();
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    duty_set_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (duty_expect.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          e = duty_expect.pop_front();
          check_field("left_fwd_duty", e.left_fwd, out_left_fwd_duty);
          check_field("left_rev_duty", e.left_rev, out_left_rev_duty);
          check_field("right_fwd_duty", e.right_fwd, out_right_fwd_duty);
          check_field("right_rev_duty", e.right_rev, out_right_rev_duty);
          check_field("range_fault", e.fault, out_range_fault);
        end
        results_seen++;
        if (results_seen % 70 == 0) recv_calm = !recv_calm;
        if (!squeeze_done && results_seen == 400) begin
          hold_left = SQUEEZE;
          squeeze_done = 1'b1;
        end else begin
          hold_left = recv_calm ? 0 : $urandom_range(0, 8);
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int lc, rc, spread, n;
    // reset calibration: full 0..4095 ranges
    add_item(lfsm_pkg::REQ_DRIVE, 0, TOP);
    add_item(lfsm_pkg::REQ_DRIVE, TOP, 0);
    add_item(lfsm_pkg::REQ_DRIVE, 2048, 2048);
    add_item(REQ_UNUSED, 1234, 2345);
    // inverted range right after calibration start
    add_item(lfsm_pkg::REQ_CAL_START, 0, 0);
    add_item(lfsm_pkg::REQ_DRIVE, 1000, 3000);
    // saturation below min and above max
    add_item(lfsm_pkg::REQ_CAL_SAMPLE, 100, 200);
    add_item(lfsm_pkg::REQ_CAL_SAMPLE, 3000, 3900);
    add_item(lfsm_pkg::REQ_DRIVE, 50, 4000);
    add_item(lfsm_pkg::REQ_DRIVE, 3000, 200);
    add_item(lfsm_pkg::REQ_DRIVE, 1550, 2050);
    // empty range on both sensors, then on the left only
    add_item(lfsm_pkg::REQ_CAL_START, TOP, TOP);
    add_item(lfsm_pkg::REQ_CAL_SAMPLE, 500, 600);
    add_item(lfsm_pkg::REQ_DRIVE, 500, 600);
    add_item(lfsm_pkg::REQ_CAL_SAMPLE, 500, 700);
    add_item(lfsm_pkg::REQ_DRIVE, 500, 650);
    add_item(REQ_UNUSED, TOP, TOP);
    // full calibrated range, all corners
    add_item(lfsm_pkg::REQ_CAL_START, 0, 0);
    add_item(lfsm_pkg::REQ_CAL_SAMPLE, 0, 0);
    add_item(lfsm_pkg::REQ_CAL_SAMPLE, TOP, TOP);
    add_item(lfsm_pkg::REQ_DRIVE, 0, TOP);
    add_item(lfsm_pkg::REQ_DRIVE, TOP, 0);
    add_item(lfsm_pkg::REQ_DRIVE, TOP, TOP);
    add_item(lfsm_pkg::REQ_DRIVE, 0, 0);

    while (items_counted < ITEM_GOAL) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4))
          add_item(RW'($urandom_range(0, 3)), $urandom_range(0, TOP), $urandom_range(0, TOP));
      end else begin
        lc = $urandom_range(0, TOP);
        rc = $urandom_range(0, TOP);
        spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, TOP);
        add_item(lfsm_pkg::REQ_CAL_START, $urandom_range(0, TOP), $urandom_range(0, TOP));
        n = $urandom_range(1, 5);
        repeat (n) add_item(lfsm_pkg::REQ_CAL_SAMPLE, near_reading(lc, spread),
                            near_reading(rc, spread));
        n = $urandom_range(3, 25);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0)
            add_item(lfsm_pkg::REQ_DRIVE, $urandom_range(0, TOP), $urandom_range(0, TOP));
          else
            add_item(lfsm_pkg::REQ_DRIVE, near_reading(lc, spread + spread / 4 + 2),
                     near_reading(rc, spread + spread / 4 + 2));
        end
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (sensor_items.size() != 0) @(posedge clk);
    while (duty_expect.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
